// File: rtl/lec_pkg.sv
`default_nettype none

package lec_pkg;

  localparam int MAX_HALF_WIDTH = 16;
  localparam int SAMPLE_BITS    = 16;

  // Width and reset value of the half_width register.
  localparam int          CFG_BITS         = 5;
  localparam logic [4:0]  HALF_WIDTH_RESET = 5'd1;

  typedef enum logic [1:0] {
    CLASS_NONE = 2'd0,
    CLASS_MAX  = 2'd1,
    CLASS_MIN  = 2'd2
  } class_t;

endpackage

`default_nettype wire

// File: rtl/lec_window.sv
`default_nettype none

module lec_window #(
  parameter int MAX_HALF_WIDTH = lec_pkg::MAX_HALF_WIDTH,
  parameter int SAMPLE_BITS    = lec_pkg::SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          shift_en,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0]      taps [2*MAX_HALF_WIDTH+1]
);

  localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;

  // Newest sample at tap 0. Taps not yet written in the current signal are
  // masked out by the classifier, so the line needs no reset.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      taps[0] <= sample;
      for (int k = 1; k < DEPTH; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/lec_classify.sv
`default_nettype none

module lec_classify #(
  parameter int MAX_HALF_WIDTH = lec_pkg::MAX_HALF_WIDTH,
  parameter int SAMPLE_BITS    = lec_pkg::SAMPLE_BITS
) (
  input  wire logic signed [SAMPLE_BITS-1:0]          taps [2*MAX_HALF_WIDTH+1],
  input  wire logic [$clog2(MAX_HALF_WIDTH+1)-1:0]    age,
  input  wire logic [$clog2(MAX_HALF_WIDTH+1)-1:0]    width,
  input  wire logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0]  oldest,
  output lec_pkg::class_t                             cls
);

  localparam int DEPTH    = 2 * MAX_HALF_WIDTH + 1;
  localparam int SUM_BITS = $clog2(DEPTH) + 1;

  logic signed [SAMPLE_BITS-1:0] center;
  logic [SUM_BITS-1:0]           age_ext;
  logic [SUM_BITS-1:0]           width_ext;
  logic [SUM_BITS-1:0]           oldest_ext;
  logic [DEPTH-1:0]              in_window;
  logic                          is_max;
  logic                          is_min;

  assign age_ext    = SUM_BITS'(age);
  assign width_ext  = SUM_BITS'(width);
  assign oldest_ext = SUM_BITS'(oldest);

  // The center can only sit in the newer half of the line.
  always_comb begin
    center = taps[0];
    for (int k = 1; k <= MAX_HALF_WIDTH; k++) begin
      if (age == ($clog2(MAX_HALF_WIDTH+1))'(k)) begin
        center = taps[k];
      end
    end
  end

  // Clamping a neighbor to the first or last sample of the signal repeats a
  // value that is already inside the window, so it is enough to compare
  // against every stored sample within the width and not older than the
  // first sample of the signal.
  always_comb begin
    is_max = 1'b1;
    is_min = 1'b1;
    for (int k = 0; k < DEPTH; k++) begin
      in_window[k] = (SUM_BITS'(k) != age_ext) &&
                     (SUM_BITS'(k) <= age_ext + width_ext) &&
                     (SUM_BITS'(k) + width_ext >= age_ext) &&
                     (SUM_BITS'(k) <= oldest_ext);
      if (in_window[k] && !(center >= taps[k])) begin
        is_max = 1'b0;
      end
      if (in_window[k] && !(center <= taps[k])) begin
        is_min = 1'b0;
      end
    end
  end

  always_comb begin
    if (is_max) begin
      cls = lec_pkg::CLASS_MAX;
    end else if (is_min) begin
      cls = lec_pkg::CLASS_MIN;
    end else begin
      cls = lec_pkg::CLASS_NONE;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lec_sequencer.sv
`default_nettype none

module lec_sequencer #(
  parameter int MAX_HALF_WIDTH = lec_pkg::MAX_HALF_WIDTH
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  input  wire logic                                   end_of_signal,
  output logic                                        in_stall,
  input  wire logic [$clog2(MAX_HALF_WIDTH+1)-1:0]    width,
  output logic                                        shift_en,
  output logic [$clog2(MAX_HALF_WIDTH+1)-1:0]         job_age,
  output logic [$clog2(MAX_HALF_WIDTH+1)-1:0]         job_width,
  output logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0]       job_oldest,
  input  wire lec_pkg::class_t                        cls,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output lec_pkg::class_t                             sample_class,
  output logic                                        last_result
);

  localparam int DEPTH     = 2 * MAX_HALF_WIDTH + 1;
  localparam int FR_BITS   = $clog2(MAX_HALF_WIDTH + 2);
  localparam int AGE_BITS  = $clog2(MAX_HALF_WIDTH + 1);
  localparam int SEEN_BITS = $clog2(DEPTH + 1);
  localparam int OLD_BITS  = $clog2(DEPTH);

  localparam logic [FR_BITS-1:0]   FR_MAX   = FR_BITS'(MAX_HALF_WIDTH + 1);
  localparam logic [SEEN_BITS-1:0] SEEN_MAX = SEEN_BITS'(DEPTH);

  logic [FR_BITS-1:0]   flush_remaining;
  logic [FR_BITS-1:0]   flush_remaining_next;
  logic [SEEN_BITS-1:0] samples_seen;
  logic [SEEN_BITS-1:0] samples_seen_next;
  logic [FR_BITS-1:0]   pending;
  logic [FR_BITS-1:0]   pending_next;
  logic                 job_last;

  logic [FR_BITS-1:0]   fr_inc;
  logic [SEEN_BITS-1:0] seen_inc;
  logic [FR_BITS-1:0]   width_ext;
  logic                 emit;
  logic                 accept;

  assign emit     = (pending != '0) && (!out_valid || !out_stall);
  // The next sample may shift the window at the edge that takes the last
  // class of the current job.
  assign in_stall = !((pending == '0) || (pending == FR_BITS'(1) && emit));
  assign accept   = in_valid && !in_stall;
  assign shift_en = accept;

  assign fr_inc    = (flush_remaining < FR_MAX) ? flush_remaining + 1'b1 : flush_remaining;
  assign seen_inc  = (samples_seen < SEEN_MAX) ? samples_seen + 1'b1 : samples_seen;
  assign width_ext = FR_BITS'(width);

  always_comb begin
    if (end_of_signal) begin
      pending_next         = fr_inc;
      flush_remaining_next = '0;
      samples_seen_next    = '0;
    end else begin
      pending_next         = (fr_inc > width_ext) ? fr_inc - width_ext : '0;
      flush_remaining_next = fr_inc - pending_next;
      samples_seen_next    = seen_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_remaining <= '0;
      samples_seen    <= '0;
      pending         <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        flush_remaining <= flush_remaining_next;
        samples_seen    <= samples_seen_next;
        pending         <= pending_next;
      end else if (emit) begin
        pending <= pending - 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Job and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      job_age    <= AGE_BITS'(fr_inc - 1'b1);
      job_width  <= width;
      job_oldest <= OLD_BITS'(seen_inc - 1'b1);
      job_last   <= end_of_signal;
    end else if (emit) begin
      job_age <= job_age - 1'b1;
    end
    if (emit) begin
      sample_class <= cls;
      last_result  <= job_last && (job_age == '0);
    end
  end

endmodule

`default_nettype wire

// File: rtl/local_extrema_classifier.sv
`default_nettype none

// Channel   Handshake              Payload
// -------   ---------------------  -----------------------------------
// input     in_valid / in_stall    sample, end_of_signal
// output    out_valid / out_stall  sample_class, last_result
// config    cfg_valid / cfg_ready  cfg_half_width
//
// A sample that releases at most one class is taken every cycle unless a
// stalled output holds a class; a completed right-hand window registers a
// job, whose class then goes to the output register. A final sample or a
// lowered half_width releases several classes, one per cycle through the
// single classifier unless the output stalls; input stalls until the last
// one is registered. Reset (synchronous) clears the counters, the output
// valid and sets half_width to 1; the sample line needs no clearing pass.

module local_extrema_classifier #(
  parameter int MAX_HALF_WIDTH = lec_pkg::MAX_HALF_WIDTH,
  parameter int SAMPLE_BITS    = lec_pkg::SAMPLE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]  sample,
  input  wire logic                           end_of_signal,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          sample_class,
  output logic                                last_result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lec_pkg::CFG_BITS-1:0]   cfg_half_width
);

  localparam int DEPTH    = 2 * MAX_HALF_WIDTH + 1;
  localparam int W_BITS   = $clog2(MAX_HALF_WIDTH + 1);
  localparam int OLD_BITS = $clog2(DEPTH);

  logic [lec_pkg::CFG_BITS-1:0]  half_width;
  logic [W_BITS-1:0]             eff_width;
  logic                          shift_en;
  logic signed [SAMPLE_BITS-1:0] taps [DEPTH];
  logic [W_BITS-1:0]             job_age;
  logic [W_BITS-1:0]             job_width;
  logic [OLD_BITS-1:0]           job_oldest;
  lec_pkg::class_t               cls;
  lec_pkg::class_t               out_class;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= lec_pkg::HALF_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_width <= cfg_half_width;
    end
  end

  // Zero acts as one, and anything above the line's reach as its maximum.
  always_comb begin
    if (half_width == '0) begin
      eff_width = W_BITS'(1);
    end else if (half_width > lec_pkg::CFG_BITS'(MAX_HALF_WIDTH)) begin
      eff_width = W_BITS'(MAX_HALF_WIDTH);
    end else begin
      eff_width = W_BITS'(half_width);
    end
  end

  lec_window #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_window (
    .clk      (clk),
    .shift_en (shift_en),
    .sample   (sample),
    .taps     (taps)
  );

  lec_classify #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_classify (
    .taps   (taps),
    .age    (job_age),
    .width  (job_width),
    .oldest (job_oldest),
    .cls    (cls)
  );

  lec_sequencer #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
  ) u_sequencer (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .end_of_signal (end_of_signal),
    .in_stall      (in_stall),
    .width         (eff_width),
    .shift_en      (shift_en),
    .job_age       (job_age),
    .job_width     (job_width),
    .job_oldest    (job_oldest),
    .cls           (cls),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_class  (out_class),
    .last_result   (last_result)
  );

  assign sample_class = out_class;

endmodule

`default_nettype wire

// File: sim/local_extrema_classifier_checker.sv
`timescale 1ns / 1ps

module local_extrema_classifier_checker
  import lec_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          end_of_signal,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic [1:0]                    sample_class,
  input  wire logic                          last_result,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [CFG_BITS-1:0]           cfg_half_width,
  output int                                 error_count,
  output int                                 classes_due,
  output int                                 classes_checked
);

  localparam int DEPTH    = 2 * MAX_HALF_WIDTH + 1;
  localparam int SEEN_MAX = 63;

  typedef struct packed {
    class_t cls;
    logic   last;
  } class_beat_t;

  logic signed [SAMPLE_BITS-1:0] history [DEPTH];
  int                            seen_count;
  int                            unclassified;
  logic [CFG_BITS-1:0]           width_reg;
  class_beat_t                   due_classes [$];
  int                            mismatches = 0;
  int                            matched = 0;

  assign error_count     = mismatches;
  assign classes_checked = matched;

  function automatic int neighbor_span();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_HALF_WIDTH) return MAX_HALF_WIDTH;
    return int'(width_reg);
  endfunction

  // Age 0 is the newest sample; neighbors past either end of the signal clamp
  // to the first or last sample held for it.
  function automatic class_t judge_extremum(int age, int span);
    int                            filled;
    int                            oldest;
    int                            li;
    int                            ri;
    logic signed [SAMPLE_BITS-1:0] center;
    logic                          peak;
    logic                          dip;
    filled = seen_count < DEPTH ? seen_count : DEPTH;
    oldest = filled > 0 ? filled - 1 : 0;
    if (age > oldest) age = oldest;
    center = history[age];
    peak = 1'b1;
    dip  = 1'b1;
    for (int j = 1; j <= span; j++) begin
      li = age + j > oldest ? oldest : age + j;
      ri = j > age ? 0 : age - j;
      if (!(center >= history[li] && center >= history[ri])) peak = 1'b0;
      if (!(center <= history[li] && center <= history[ri])) dip = 1'b0;
    end
    if (peak) return CLASS_MAX;
    if (dip) return CLASS_MIN;
    return CLASS_NONE;
  endfunction

  task automatic release_class(input int span, input logic last);
    class_beat_t beat;
    beat.cls  = judge_extremum(unclassified - 1, span);
    beat.last = last;
    due_classes = {due_classes, beat};
    unclassified--;
  endtask

  task automatic absorb_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic eos);
    int span;
    span = neighbor_span();
    for (int k = DEPTH - 1; k > 0; k--) history[k] = history[k-1];
    history[0] = value;
    if (seen_count < SEEN_MAX) seen_count++;
    if (unclassified < MAX_HALF_WIDTH + 1) unclassified++;
    if (eos) begin
      while (unclassified > 0) release_class(span, unclassified == 1);
      seen_count = 0;
    end else begin
      while (unclassified > span) release_class(span, 1'b0);
    end
  endtask

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_beat();
    class_beat_t want;
    if (due_classes.size() == 0) begin
      report($sformatf("class %0d (last %0b) arrived with none expected",
                       sample_class, last_result));
      return;
    end
    want = due_classes.pop_front();
    matched++;
    if (sample_class !== want.cls)
      report($sformatf("sample_class expected %0d, got %0d", want.cls, sample_class));
    if (last_result !== want.last)
      report($sformatf("last_result expected %0b, got %0b", want.last, last_result));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seen_count   = 0;
      unclassified = 0;
      width_reg    = HALF_WIDTH_RESET;
      due_classes.delete();
    end else begin
      if (cfg_valid && cfg_ready) width_reg = cfg_half_width;
      if (in_valid && !in_stall) absorb_sample(sample, end_of_signal);
      if (out_valid && !out_stall) check_beat();
    end
    classes_due <= due_classes.size();
  end

endmodule

// File: sim/local_extrema_classifier_test.sv
`timescale 1ns / 1ps

module local_extrema_classifier_test;
  import lec_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = MAX_HALF_WIDTH + 4;
  localparam int RANDOM_ITEMS = 270;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_signal;
  logic                          out_valid;
  logic                          out_stall;
  logic [1:0]                    sample_class;
  logic                          last_result;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_BITS-1:0]           cfg_half_width;

  int errors;
  int classes_due;
  int classes_checked;
  int cycles = 0;
  int samples_sent = 0;
  int signals_sent = 0;
  int width_writes = 0;
  bit calm = 1'b0;

  local_extrema_classifier uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .end_of_signal  (end_of_signal),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sample_class   (sample_class),
    .last_result    (last_result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_half_width (cfg_half_width)
  );

  local_extrema_classifier_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample          (sample),
    .end_of_signal   (end_of_signal),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sample_class    (sample_class),
    .last_result     (last_result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_half_width  (cfg_half_width),
    .error_count     (errors),
    .classes_due     (classes_due),
    .classes_checked (classes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= (rst || calm) ? 1'b0 : ($urandom_range(99) < 14);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d classes outstanding.",
               cycles, classes_due);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic eos);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    sample        <= value;
    end_of_signal <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    if (eos) signals_sent++;
  endtask

  task automatic send_run(input int vals[$], input bit close);
    foreach (vals[i]) send_sample(SAMPLE_BITS'(vals[i]), close && i == vals.size() - 1);
  endtask

  // Holds the input back until every class owed has been seen, then lets the
  // block finish any flush that releases nothing further.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (classes_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [CFG_BITS-1:0] value);
    settle();
    cfg_valid      <= 1'b1;
    cfg_half_width <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    width_writes++;
  endtask

  function automatic logic [CFG_BITS-1:0] pick_width();
    case ($urandom_range(4))
      0:       return '0;
      1:       return CFG_BITS'(1);
      2:       return CFG_BITS'(MAX_HALF_WIDTH);
      3:       return {CFG_BITS{1'b1}};
      default: return CFG_BITS'($urandom_range(31));
    endcase
  endfunction

  // Sample shapes: full-range noise, a narrow band full of ties, the two
  // extremes only, and a random walk.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
      input int style, input logic signed [SAMPLE_BITS-1:0] prev);
    case (style)
      0:       return SAMPLE_BITS'($urandom);
      1:       return SAMPLE_BITS'(int'($urandom_range(4)) - 2);
      2:       return $urandom_range(1) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                        : {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      default: return SAMPLE_BITS'(int'(prev) + int'($urandom_range(64)) - 32);
    endcase
  endfunction

  initial begin
    int                            vals[$];
    int                            random_sent;
    int                            len;
    int                            style;
    int                            split;
    logic signed [SAMPLE_BITS-1:0] prev;

    rst            = 1'b1;
    in_valid       = 1'b0;
    sample         = '0;
    end_of_signal  = 1'b0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_half_width = HALF_WIDTH_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A signal of one sample, then extremes at the reset width.
    vals = '{32767};
    send_run(vals, 1'b1);
    vals = '{-32768, 32767, -32768, 0, 1, 2};
    send_run(vals, 1'b1);

    write_width('0);
    vals = '{3, 1, 2};
    send_run(vals, 1'b1);

    // Oversized width on a signal far shorter than the window.
    write_width({CFG_BITS{1'b1}});
    vals = '{10, -10, 20, 20, -30};
    send_run(vals, 1'b1);

    // Narrowing the window in the middle of a signal releases a burst.
    write_width(CFG_BITS'(4));
    vals = '{5, -3, 8, 8, 1, -7, 2, 9};
    send_run(vals, 1'b0);
    write_width(CFG_BITS'(1));
    vals = '{4, -4, 6};
    send_run(vals, 1'b1);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 30) write_width(pick_width());
      calm <= random_sent >= 100 && random_sent < 180;
      case ($urandom_range(9))
        0:       len = $urandom_range(80, 64);
        1, 2:    len = $urandom_range(40, 17);
        default: len = $urandom_range(16, 1);
      endcase
      if (signals_sent == 8) len = 70;
      if (len > RANDOM_ITEMS - random_sent) len = RANDOM_ITEMS - random_sent;
      style = $urandom_range(3);
      split = (len > 4 && $urandom_range(99) < 12) ? $urandom_range(len - 2, 1) : -1;
      prev = pick_sample(0, '0);
      for (int k = 0; k < len; k++) begin
        if (k == split) write_width(pick_width());
        prev = pick_sample(style, prev);
        send_sample(prev, k == len - 1);
        random_sent++;
      end
    end

    settle();
    $display("Classified %0d samples over %0d signals with %0d half_width writes,",
             samples_sent, signals_sent, width_writes);
    $display("%0d classes compared against the expected stream.", classes_checked);
    if (errors == 0 && classes_due == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
